// ===== src/crc8pf_pkg.sv =====
package crc8pf_pkg;

    // default payload buffer depth
    localparam int PAYLOAD_MAX_DEF = 64;

    // event queue between parser and output side
    localparam int QUEUE_DEPTH = 2;

    // transaction kinds on the request channel
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOISE    = 3'd1;
    localparam logic [2:0] ST_TOO_LONG = 3'd2;
    localparam logic [2:0] ST_BAD_CRC  = 3'd3;
    localparam logic [2:0] ST_TIMEOUT  = 3'd4;

    // register map
    localparam logic REG_START   = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    localparam logic [7:0]  START_BYTE_RST = 8'd213;
    localparam logic [15:0] TIMEOUT_RST    = 16'd13;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic [5:0] frame_length;
        logic       last;
    } rsp_t;

    // one finished frame or error, handed from parser to output side
    typedef struct packed {
        logic [2:0] status;
        logic [5:0] length;
    } event_t;

    // reflected crc-8, polynomial 0x8c, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ 8'h8C;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== src/crc8pf_ram.sv =====
module crc8pf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/crc8pf_front.sv =====
module crc8pf_front #(
    parameter int PAYLOAD_MAX = crc8pf_pkg::PAYLOAD_MAX_DEF,
    localparam int AW = $clog2(PAYLOAD_MAX)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  crc8pf_pkg::req_t    req,
    output logic                req_stall,
    input  logic [7:0]          open_byte,
    input  logic [15:0]         timeout_ticks,
    input  logic                q_full,
    output logic                push,
    output crc8pf_pkg::event_t  push_event,
    output logic                wr_en,
    output logic [AW-1:0]       wr_addr,
    output logic [7:0]          wr_data,
    input  logic                drain_done
);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_LEN     = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_CRC     = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [5:0]  expected_reg, expected_next;
    logic [5:0]  received_reg, received_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] ticks_reg, ticks_next;
    logic        hold_reg, hold_next;

    logic        accept;
    logic        go_idle;
    logic [15:0] ticks_inc;
    logic [5:0]  received_inc;

    // hold off input while the event queue is full or the buffer is being drained
    assign req_stall = q_full || hold_reg;
    assign accept    = req_valid && !req_stall;

    assign ticks_inc    = ticks_reg + 16'd1;
    assign received_inc = received_reg + 6'd1;

    // parser, one transaction per cycle while req_stall is low
    always_comb
    begin
        phase_next    = phase_reg;
        expected_next = expected_reg;
        received_next = received_reg;
        crc_next      = crc_reg;
        ticks_next    = ticks_reg;
        hold_next     = hold_reg;
        go_idle       = 1'b0;
        push          = 1'b0;
        push_event    = '0;
        wr_en         = 1'b0;
        wr_addr       = received_reg[AW-1:0];
        wr_data       = req.rx_byte;

        if (drain_done)
        begin
            hold_next = 1'b0;
        end

        if (accept)
        begin
            if (req.command == crc8pf_pkg::CMD_TICK)
            begin
                // ticks only count inside an open frame
                if (phase_reg != PH_IDLE)
                begin
                    ticks_next = ticks_inc;
                    if (ticks_inc >= timeout_ticks)
                    begin
                        push              = 1'b1;
                        push_event.status = crc8pf_pkg::ST_TIMEOUT;
                        go_idle           = 1'b1;
                    end
                end
            end
            else
            begin
                case (phase_reg)
                    PH_IDLE:
                    begin
                        if (req.rx_byte == open_byte)
                        begin
                            go_idle    = 1'b1;
                            phase_next = PH_LEN;
                        end
                        else
                        begin
                            push              = 1'b1;
                            push_event.status = crc8pf_pkg::ST_NOISE;
                            go_idle           = 1'b1;
                        end
                    end
                    PH_LEN:
                    begin
                        if ({1'b0, req.rx_byte} < 9'(PAYLOAD_MAX))
                        begin
                            expected_next = req.rx_byte[5:0];
                            phase_next    = (req.rx_byte[5:0] == 6'd0) ? PH_CRC : PH_PAYLOAD;
                        end
                        else
                        begin
                            push              = 1'b1;
                            push_event.status = crc8pf_pkg::ST_TOO_LONG;
                            go_idle           = 1'b1;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        wr_en         = 1'b1;
                        crc_next      = crc8pf_pkg::crc8_byte(crc_reg, req.rx_byte);
                        received_next = received_inc;
                        if (received_inc >= expected_reg)
                        begin
                            phase_next = PH_CRC;
                        end
                    end
                    PH_CRC:
                    begin
                        push = 1'b1;
                        if (crc_reg != req.rx_byte)
                        begin
                            push_event.status = crc8pf_pkg::ST_BAD_CRC;
                        end
                        else
                        begin
                            push_event.status = crc8pf_pkg::ST_OK;
                            push_event.length = expected_reg;
                            hold_next         = (expected_reg != 6'd0);
                        end
                        go_idle = 1'b1;
                    end
                    default:
                    begin
                        go_idle = 1'b1;
                    end
                endcase
            end
        end

        // common frame teardown, start byte reopens right after
        if (go_idle)
        begin
            if (!(accept && req.command == crc8pf_pkg::CMD_BYTE && phase_reg == PH_IDLE
                  && req.rx_byte == open_byte))
            begin
                phase_next = PH_IDLE;
            end
            expected_next = 6'd0;
            received_next = 6'd0;
            crc_next      = 8'd0;
            ticks_next    = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            expected_reg <= 6'd0;
            received_reg <= 6'd0;
            crc_reg      <= 8'd0;
            ticks_reg    <= 16'd0;
            hold_reg     <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            expected_reg <= expected_next;
            received_reg <= received_next;
            crc_reg      <= crc_next;
            ticks_reg    <= ticks_next;
            hold_reg     <= hold_next;
        end
    end

endmodule

// ===== src/crc8pf_queue.sv =====
module crc8pf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  crc8pf_pkg::event_t  push_event,
    input  logic                pop,
    output logic                q_valid,
    output crc8pf_pkg::event_t  q_event,
    output logic                q_full
);

    localparam int QD  = crc8pf_pkg::QUEUE_DEPTH;
    localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCW = $clog2(QD + 1);

    crc8pf_pkg::event_t entry_reg [QD];
    logic [QAW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]     count_reg, count_next;

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == QCW'(QD));
    assign q_event = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // event storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_event;
        end
    end

endmodule

// ===== src/crc8pf_back.sv =====
module crc8pf_back #(
    parameter int PAYLOAD_MAX = crc8pf_pkg::PAYLOAD_MAX_DEF,
    localparam int AW = $clog2(PAYLOAD_MAX)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  crc8pf_pkg::event_t  q_event,
    output logic                pop,
    output logic                rd_en,
    output logic [AW-1:0]       rd_addr,
    input  logic [7:0]          rd_data,
    output logic                rsp_valid,
    output crc8pf_pkg::rsp_t    rsp,
    input  logic                rsp_stall,
    output logic                drain_done
);

    localparam logic B_IDLE = 1'b0;
    localparam logic B_SEND = 1'b1;

    logic             state_reg, state_next;
    logic [5:0]       idx_reg, idx_next;
    logic [5:0]       len_reg, len_next;
    logic             out_valid_reg, out_valid_next;
    crc8pf_pkg::rsp_t out_reg, out_next;

    logic             out_free;
    logic [5:0]       idx_inc;

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign idx_inc   = idx_reg + 6'd1;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // event decode and payload drain
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_next       = out_reg;
        pop            = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = idx_inc[AW-1:0];
        drain_done     = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_event.status != crc8pf_pkg::ST_OK || q_event.length == 6'd0)
                    begin
                        // single result: error or empty frame
                        if (out_free)
                        begin
                            pop                   = 1'b1;
                            out_valid_next        = 1'b1;
                            out_next.status       = q_event.status;
                            out_next.payload_byte = 8'd0;
                            out_next.byte_valid   = 1'b0;
                            out_next.frame_length = 6'd0;
                            out_next.last         = 1'b1;
                        end
                    end
                    else
                    begin
                        // fetch first payload byte
                        pop        = 1'b1;
                        len_next   = q_event.length;
                        idx_next   = 6'd0;
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = B_SEND;
                    end
                end
            end
            B_SEND:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.status       = crc8pf_pkg::ST_OK;
                    out_next.payload_byte = rd_data;
                    out_next.byte_valid   = 1'b1;
                    out_next.frame_length = len_reg;
                    out_next.last         = (idx_inc == len_reg);
                    if (idx_inc == len_reg)
                    begin
                        drain_done = 1'b1;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                        rd_en    = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            idx_reg       <= 6'd0;
            len_reg       <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

// ===== src/crc8_packet_frame_receiver.sv =====
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  command, rx_byte
// rsp       out        rsp_valid / rsp_stall  status, payload_byte, byte_valid, frame_length, last
// apb       in/out     psel, penable, pready  open byte (0x0), timeout_ticks (0x4)
//
// the parser takes one request transaction per cycle while req_stall is low and updates crc in that cycle
// after a good frame with a non-empty payload, requests stall while the
// payload drains through the single read port of the frame buffer, and longer under any rsp stall
// reset clears parser, event queue and output valid; the buffer ram is not cleared
// requests also stall when the two-entry event queue is full
module crc8_packet_frame_receiver #(
    parameter int PAYLOAD_MAX = crc8pf_pkg::PAYLOAD_MAX_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  crc8pf_pkg::req_t  req,
    output logic              req_stall,
    output logic              rsp_valid,
    output crc8pf_pkg::rsp_t  rsp,
    input  logic              rsp_stall,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int AW = $clog2(PAYLOAD_MAX);

    logic [7:0]  start_reg;
    logic [15:0] timeout_reg;

    logic               push, pop, q_valid, q_full;
    crc8pf_pkg::event_t push_event, q_event;
    logic               wr_en, rd_en;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [7:0]         wr_data, rd_data;
    logic               drain_done;

    // configuration registers
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= crc8pf_pkg::START_BYTE_RST;
            timeout_reg <= crc8pf_pkg::TIMEOUT_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                crc8pf_pkg::REG_START:   start_reg   <= pwdata[7:0];
                crc8pf_pkg::REG_TIMEOUT: timeout_reg <= pwdata[15:0];
                default:                 start_reg   <= start_reg;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (paddr[2])
            crc8pf_pkg::REG_START:   prdata = {24'd0, start_reg};
            crc8pf_pkg::REG_TIMEOUT: prdata = {16'd0, timeout_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    crc8pf_front #(
        .PAYLOAD_MAX(PAYLOAD_MAX)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req           (req),
        .req_stall     (req_stall),
        .open_byte     (start_reg),
        .timeout_ticks (timeout_reg),
        .q_full        (q_full),
        .push          (push),
        .push_event    (push_event),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .drain_done    (drain_done)
    );

    crc8pf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_event (push_event),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_event    (q_event),
        .q_full     (q_full)
    );

    crc8pf_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_MAX)
    ) u_buffer (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    crc8pf_back #(
        .PAYLOAD_MAX(PAYLOAD_MAX)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_event    (q_event),
        .pop        (pop),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .rsp_valid  (rsp_valid),
        .rsp        (rsp),
        .rsp_stall  (rsp_stall),
        .drain_done (drain_done)
    );

endmodule
